/* hw/rtl/hsl_pkg.sv */
// ----------------------------------------------------------------------------
// hsl_pkg
// Types, constants and the sector routing table for the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

   localparam int UNIT_ONE     = 4096;
   localparam int FULL_TURN    = 23040;
   localparam int SECTOR_UNITS = 3840;
   localparam int PAIR_UNITS   = 7680;
   localparam int HALF_SECTOR  = 1920;
   localparam int RECIP_15     = 2185;   // ceil(2^15 / 15)

   // channel value denominator 4096*4096*3840
   localparam logic [37:0] DEN        = 38'd64424509440;
   // half a denominator, the rounding bias after scaling by 255
   localparam logic [43:0] ROUND_BIAS = 44'd32212254720;

   typedef logic signed [37:0] hsl_wide_type;

   typedef enum logic [1:0] {
      CH_HI,
      CH_X,
      CH_LO
   } hsl_sel_type;

   typedef struct packed {
      hsl_sel_type r;
      hsl_sel_type g;
      hsl_sel_type b;
   } hsl_route_type;

   typedef struct packed {
      logic s4;
      logic s5;
      logic s6;
   } hsl_adv_type;

   function automatic hsl_route_type hsl_route(input logic [2:0] sector);
      hsl_route_type rt;
      case (sector)
         3'd0: rt = '{r: CH_HI, g: CH_X,  b: CH_LO};
         3'd1: rt = '{r: CH_X,  g: CH_HI, b: CH_LO};
         3'd2: rt = '{r: CH_LO, g: CH_HI, b: CH_X };
         3'd3: rt = '{r: CH_LO, g: CH_X,  b: CH_HI};
         3'd4: rt = '{r: CH_X,  g: CH_LO, b: CH_HI};
         default: rt = '{r: CH_HI, g: CH_LO, b: CH_X };
      endcase
      return rt;
   endfunction

endpackage

/* hw/rtl/hsl_to_rgb_converter_unit.sv */
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit
// HSL pixel to 8-bit RGB, exact rational arithmetic, six-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_hue, req_saturation, req_lightness
//  rsp     | out       | rsp_valid, rsp_stall, rsp_red, rsp_green, rsp_blue
//
//  rsp_valid rises when an accepted item reaches stage 6; one item per cycle while rsp_stall is low.
//  Each stage holds a valid bit and loads when empty or when the next one moves,
//  so bubbles collapse while rsp is stalled.
//  req_stall rises only when all six stages are full and rsp_stall is high.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [14:0] req_hue,
   input  logic [12:0] req_saturation,
   input  logic [12:0] req_lightness,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);
   import hsl_pkg::*;

   logic [5:0] valid_in, valid_ff;
   logic [5:0] en;

   // stage 1
   logic [14:0] s1_hue_in, s1_hue_ff;
   logic [12:0] s1_sat_in, s1_sat_ff;
   logic [12:0] s1_light_in, s1_light_ff;
   logic [12:0] s1_span_in, s1_span_ff;
   logic [13:0] two_l;
   logic [12:0] l_off;

   // stage 2
   logic [24:0] s2_cc_in, s2_cc_ff;
   logic [2:0]  s2_sector_in, s2_sector_ff;
   logic [11:0] s2_tri_in, s2_tri_ff;
   logic [12:0] s2_light_ff;
   logic [12:0] rem;

   // stage 3
   hsl_wide_type  s3_p_hi_in, s3_p_hi_ff;
   hsl_wide_type  s3_p_x_in, s3_p_x_ff;
   hsl_wide_type  s3_base_in, s3_base_ff;
   hsl_route_type s3_route_ff;
   logic signed [25:0] cc_s;
   logic signed [12:0] tri_off;

   hsl_adv_type adv;

   // ---- handshake ----
   always_comb begin
      en[5] = !valid_ff[5] || !rsp_stall;
      for (int i = 4; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i + 1];
      end
      valid_in = {valid_ff[4:0], req_valid};
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[5];
   assign adv       = '{s4: en[3], s5: en[4], s6: en[5]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < 6; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // ---- stage 1: wrap hue, clamp s and l, 1-|2l-1| ----
   always_comb begin
      s1_hue_in   = (req_hue >= 15'(FULL_TURN)) ? req_hue - 15'(FULL_TURN) : req_hue;
      s1_sat_in   = (req_saturation > 13'(UNIT_ONE)) ? 13'(UNIT_ONE) : req_saturation;
      s1_light_in = (req_lightness > 13'(UNIT_ONE)) ? 13'(UNIT_ONE) : req_lightness;
      two_l       = {s1_light_in, 1'b0};
      if (two_l >= 14'(UNIT_ONE)) begin
         l_off = 13'(two_l - 14'(UNIT_ONE));
      end else begin
         l_off = 13'(14'(UNIT_ONE) - two_l);
      end
      s1_span_in = 13'(UNIT_ONE) - l_off;
   end

   // ---- stage 2: chroma, sector, triangle ----
   always_comb begin
      s2_cc_in = 25'(26'(s1_span_ff) * 26'(s1_sat_ff));
      if (s1_hue_ff >= 15'(5 * SECTOR_UNITS)) begin
         s2_sector_in = 3'd5;
      end else if (s1_hue_ff >= 15'(4 * SECTOR_UNITS)) begin
         s2_sector_in = 3'd4;
      end else if (s1_hue_ff >= 15'(3 * SECTOR_UNITS)) begin
         s2_sector_in = 3'd3;
      end else if (s1_hue_ff >= 15'(2 * SECTOR_UNITS)) begin
         s2_sector_in = 3'd2;
      end else if (s1_hue_ff >= 15'(SECTOR_UNITS)) begin
         s2_sector_in = 3'd1;
      end else begin
         s2_sector_in = 3'd0;
      end
      if (s1_hue_ff >= 15'(2 * PAIR_UNITS)) begin
         rem = 13'(s1_hue_ff - 15'(2 * PAIR_UNITS));
      end else if (s1_hue_ff >= 15'(PAIR_UNITS)) begin
         rem = 13'(s1_hue_ff - 15'(PAIR_UNITS));
      end else begin
         rem = 13'(s1_hue_ff);
      end
      s2_tri_in = (rem <= 13'(SECTOR_UNITS)) ? 12'(rem) : 12'(13'(PAIR_UNITS) - rem);
   end

   // ---- stage 3: products ----
   always_comb begin
      cc_s       = $signed({1'b0, s2_cc_ff});
      tri_off    = $signed({1'b0, s2_tri_ff}) - $signed(13'(HALF_SECTOR));
      s3_p_x_in  = hsl_wide_type'(cc_s) * hsl_wide_type'(tri_off);
      s3_p_hi_in = $signed(38'(36'(s2_cc_ff) * 36'(HALF_SECTOR)));
      s3_base_in = $signed(38'({24'(24'(s2_light_ff) * 24'(SECTOR_UNITS)), 12'd0}));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_hue_ff   <= s1_hue_in;
         s1_sat_ff   <= s1_sat_in;
         s1_light_ff <= s1_light_in;
         s1_span_ff  <= s1_span_in;
      end
      if (en[1]) begin
         s2_cc_ff     <= s2_cc_in;
         s2_sector_ff <= s2_sector_in;
         s2_tri_ff    <= s2_tri_in;
         s2_light_ff  <= s1_light_ff;
      end
      if (en[2]) begin
         s3_p_hi_ff  <= s3_p_hi_in;
         s3_p_x_ff   <= s3_p_x_in;
         s3_base_ff  <= s3_base_in;
         s3_route_ff <= hsl_route(s2_sector_ff);
      end
   end

   // ---- stages 4 to 6 ----
   hsl_chan_scale u_red (
      .clock     (clock),
      .adv       (adv),
      .sel       (s3_route_ff.r),
      .base      (s3_base_ff),
      .p_hi      (s3_p_hi_ff),
      .p_x       (s3_p_x_ff),
      .chan_byte (rsp_red)
   );

   hsl_chan_scale u_green (
      .clock     (clock),
      .adv       (adv),
      .sel       (s3_route_ff.g),
      .base      (s3_base_ff),
      .p_hi      (s3_p_hi_ff),
      .p_x       (s3_p_x_ff),
      .chan_byte (rsp_green)
   );

   hsl_chan_scale u_blue (
      .clock     (clock),
      .adv       (adv),
      .sel       (s3_route_ff.b),
      .base      (s3_base_ff),
      .p_hi      (s3_p_hi_ff),
      .p_x       (s3_p_x_ff),
      .chan_byte (rsp_blue)
   );

   // ---- checks ----
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff) && rsp_stall)
      else $error("req stalled with a free stage");

   a_s1_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> s1_hue_ff < 15'(FULL_TURN) && s1_sat_ff <= 13'(UNIT_ONE)
                      && s1_light_ff <= 13'(UNIT_ONE) && s1_span_ff <= 13'(UNIT_ONE))
      else $error("stage 1 value out of range");

   a_s2_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> s2_sector_ff <= 3'd5 && s2_tri_ff <= 12'(SECTOR_UNITS))
      else $error("stage 2 sector or triangle out of range");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] && en[5] |=> rsp_valid)
      else $error("item lost between last two stages");

endmodule

/* hw/rtl/hsl_chan_scale.sv */
// ----------------------------------------------------------------------------
// hsl_chan_scale
// Per-channel back end: picks the chroma term, adds m, clamps, scales by 255
// and rounds half up over three register stages.
// ----------------------------------------------------------------------------
module hsl_chan_scale (
   input  logic                 clock,
   input  hsl_pkg::hsl_adv_type adv,
   input  hsl_pkg::hsl_sel_type sel,
   input  hsl_pkg::hsl_wide_type base,
   input  hsl_pkg::hsl_wide_type p_hi,
   input  hsl_pkg::hsl_wide_type p_x,
   output logic [7:0]           chan_byte
);
   import hsl_pkg::*;

   hsl_wide_type term;
   hsl_wide_type sum;
   logic [35:0]  vc_in, vc_ff;
   logic [43:0]  n_scaled;
   logic [11:0]  x_in, x_ff;
   logic [23:0]  q_prod;
   logic [7:0]   byte_in, byte_ff;

   always_comb begin
      case (sel)
         CH_HI:   term = p_hi;
         CH_X:    term = p_x;
         CH_LO:   term = -p_hi;
         default: term = '0;
      endcase
      sum = base + term;
      if (sum < 0) begin
         vc_in = '0;
      end else if (sum > $signed(DEN)) begin
         vc_in = DEN[35:0];
      end else begin
         vc_in = sum[35:0];
      end
   end

   // floor((v*255 + D/2) / 2^32), then divide by 15
   assign n_scaled = 44'(vc_ff) * 44'd255 + ROUND_BIAS;
   assign x_in     = n_scaled[43:32];
   assign q_prod   = 24'(x_ff) * 24'(RECIP_15);
   assign byte_in  = q_prod[22:15];

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         vc_ff <= vc_in;
      end
      if (adv.s5) begin
         x_ff <= x_in;
      end
      if (adv.s6) begin
         byte_ff <= byte_in;
      end
   end

   assign chan_byte = byte_ff;

endmodule
